// ===== rtl/core/fixed_length_frame_sync_parser_assert.svh =====
// Assertion macros used by the frame sync parser RTL.
// Used by the top level only; depends on nothing else.
`ifndef FIXED_LENGTH_FRAME_SYNC_PARSER_ASSERT_SVH
`define FIXED_LENGTH_FRAME_SYNC_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FLFS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame sync parser assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FLFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame sync parser assertion failed");

`endif

// ===== rtl/core/flfs_pkg.sv =====
// Shared types and constants for the fixed-length frame sync parser.
// Used by the controller, the datapath and the top level.
package flfs_pkg;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_HEADER_A = 2'd0;
  localparam logic [1:0] REG_FOOTER_A = 2'd1;
  localparam logic [1:0] REG_HEADER_B = 2'd2;
  localparam logic [1:0] REG_FOOTER_B = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [7:0] HEADER_A_RST = 8'd165;
  localparam logic [7:0] FOOTER_A_RST = 8'd90;
  localparam logic [7:0] HEADER_B_RST = 8'd170;
  localparam logic [7:0] FOOTER_B_RST = 8'd85;

  // Event codes reported with each result word.
  typedef enum logic [2:0] {
    EV_COLLECT = 3'd0,
    EV_DISCARD = 3'd1,
    EV_VALID   = 3'd2,
    EV_RESYNC  = 3'd3,
    EV_DROP    = 3'd4
  } ev_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_HUNT,
    ST_COLLECT,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start_frame;  // latch the input word as header, store it at entry 0
    logic collect;      // store the input word at the fill index and advance
    logic load_status;  // load a status result into the output register
    ev_t  ev;           // event code of that status result
    logic emit_rd;      // read the next frame entry into the output register
    logic inc_drop;
    logic inc_good;
    logic inc_bad;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rx_is_hdr;   // input word matches one of the headers
    logic at_last;     // the next collected word completes the frame
    logic frame_good;  // stored header is valid and input word is its footer
    logic emit_last;   // the emit pointer is at the final frame entry
  } sts_t;

endpackage

// ===== rtl/core/flfs_ctrl.sv =====
// Controller state machine of the frame sync parser.
// Depends on flfs_pkg; drives the datapath through cmd_t and reads sts_t.
module flfs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  flfs_pkg::sts_t  sts,
  output flfs_pkg::cmd_t  cmd
);

  flfs_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;
  logic             accept;

  // The output register can take a new word when empty or being drained.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r == flfs_pkg::ST_EMIT) || !out_free;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      flfs_pkg::ST_HUNT: begin
        if (accept && sts.rx_is_hdr) state_nxt = flfs_pkg::ST_COLLECT;
      end
      flfs_pkg::ST_COLLECT: begin
        if (accept && sts.at_last) begin
          if (sts.frame_good)     state_nxt = flfs_pkg::ST_EMIT;
          else if (sts.rx_is_hdr) state_nxt = flfs_pkg::ST_COLLECT;
          else                    state_nxt = flfs_pkg::ST_HUNT;
        end
      end
      flfs_pkg::ST_EMIT: begin
        if (out_free && sts.emit_last) state_nxt = flfs_pkg::ST_HUNT;
      end
      default: state_nxt = flfs_pkg::ST_HUNT;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd = '0;
    cmd.ev = flfs_pkg::EV_COLLECT;
    unique case (state_r)
      flfs_pkg::ST_HUNT: begin
        if (accept) begin
          cmd.load_status = 1'b1;
          if (sts.rx_is_hdr) begin
            cmd.start_frame = 1'b1;
          end else begin
            cmd.inc_drop = 1'b1;
            cmd.ev       = flfs_pkg::EV_DISCARD;
          end
        end
      end
      flfs_pkg::ST_COLLECT: begin
        if (accept) begin
          cmd.collect = 1'b1;
          if (!sts.at_last) begin
            cmd.load_status = 1'b1;
          end else if (sts.frame_good) begin
            cmd.inc_good = 1'b1;
          end else begin
            cmd.inc_bad     = 1'b1;
            cmd.load_status = 1'b1;
            if (sts.rx_is_hdr) begin
              cmd.start_frame = 1'b1;
              cmd.ev          = flfs_pkg::EV_RESYNC;
            end else begin
              cmd.ev = flfs_pkg::EV_DROP;
            end
          end
        end
      end
      flfs_pkg::ST_EMIT: begin
        cmd.emit_rd = out_free;
      end
      default: cmd = '0;
    endcase
  end

  // Output register occupancy.
  always_comb begin
    if (cmd.load_status || cmd.emit_rd) out_valid_nxt = 1'b1;
    else if (!out_stall)                out_valid_nxt = 1'b0;
    else                                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= flfs_pkg::ST_HUNT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/flfs_dpath.sv =====
// Datapath of the frame sync parser: registers, frame store, counters, output word.
// Depends on flfs_pkg; steered by flfs_ctrl through cmd_t.
module flfs_dpath #(
  parameter int FRAME_LEN = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [7:0]      cfg_wdata,
  input  logic [7:0]      rx_byte,
  input  flfs_pkg::cmd_t  cmd,
  output flfs_pkg::sts_t  sts,
  output logic            out_kind,
  output logic [7:0]      out_byte,
  output logic [4:0]      out_frame_pos,
  output logic            out_last,
  output logic [2:0]      out_event_res,
  output logic [31:0]     out_discarded_count,
  output logic [31:0]     out_valid_count,
  output logic [31:0]     out_invalid_count
);

  localparam int IDX_W = $clog2(FRAME_LEN);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

  logic [7:0]       header_a_r, footer_a_r, header_b_r, footer_b_r;
  logic [7:0]       hdr_r;
  logic [IDX_W-1:0] fill_r;
  logic [IDX_W-1:0] emit_idx_r;
  logic [31:0]      drop_cnt_r, good_cnt_r, bad_cnt_r;
  logic [7:0]       store_mem [FRAME_LEN];
  logic [IDX_W-1:0] wr_addr;
  logic [7:0]       footer_sel;
  logic             out_kind_r, out_last_r;
  logic [7:0]       out_byte_r;
  logic [4:0]       out_pos_r;
  logic [2:0]       out_ev_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_a_r <= flfs_pkg::HEADER_A_RST;
      footer_a_r <= flfs_pkg::FOOTER_A_RST;
      header_b_r <= flfs_pkg::HEADER_B_RST;
      footer_b_r <= flfs_pkg::FOOTER_B_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        flfs_pkg::REG_HEADER_A: header_a_r <= cfg_wdata;
        flfs_pkg::REG_FOOTER_A: footer_a_r <= cfg_wdata;
        flfs_pkg::REG_HEADER_B: header_b_r <= cfg_wdata;
        flfs_pkg::REG_FOOTER_B: footer_b_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Header and footer checks. The footer follows the stored header, with
  // header A taking precedence when both headers are equal.
  assign footer_sel     = (hdr_r == header_a_r) ? footer_a_r : footer_b_r;
  assign sts.rx_is_hdr  = (rx_byte == header_a_r) || (rx_byte == header_b_r);
  assign sts.frame_good = ((hdr_r == header_a_r) || (hdr_r == header_b_r)) &&
                          (rx_byte == footer_sel);
  assign sts.at_last    = (fill_r == LAST_IDX);
  assign sts.emit_last  = (emit_idx_r == LAST_IDX);

  // Header latch, fill index and emit pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      emit_idx_r <= '0;
    end else begin
      if (cmd.start_frame)  fill_r <= IDX_W'(1);
      else if (cmd.collect) fill_r <= fill_r + IDX_W'(1);
      if (cmd.inc_good)     emit_idx_r <= '0;
      else if (cmd.emit_rd) emit_idx_r <= emit_idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_frame) hdr_r <= rx_byte;
  end

  // Frame store: one write port; a new header always lands at entry 0.
  assign wr_addr = cmd.start_frame ? '0 : fill_r;

  always_ff @(posedge clk) begin
    if (cmd.start_frame || cmd.collect) store_mem[wr_addr] <= rx_byte;
  end

  // Wrapping event counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_cnt_r <= '0;
      good_cnt_r <= '0;
      bad_cnt_r  <= '0;
    end else begin
      if (cmd.inc_drop) drop_cnt_r <= drop_cnt_r + 32'd1;
      if (cmd.inc_good) good_cnt_r <= good_cnt_r + 32'd1;
      if (cmd.inc_bad)  bad_cnt_r  <= bad_cnt_r + 32'd1;
    end
  end

  // Output word: a status result or the registered read of a frame entry.
  always_ff @(posedge clk) begin
    if (cmd.emit_rd) begin
      out_kind_r <= 1'b1;
      out_byte_r <= store_mem[emit_idx_r];
      out_pos_r  <= 5'(emit_idx_r);
      out_last_r <= (emit_idx_r == LAST_IDX);
      out_ev_r   <= flfs_pkg::EV_VALID;
    end else if (cmd.load_status) begin
      out_kind_r <= 1'b0;
      out_byte_r <= rx_byte;
      out_pos_r  <= '0;
      out_last_r <= 1'b1;
      out_ev_r   <= cmd.ev;
    end
  end

  assign out_kind            = out_kind_r;
  assign out_byte            = out_byte_r;
  assign out_frame_pos       = out_pos_r;
  assign out_last            = out_last_r;
  assign out_event_res       = out_ev_r;
  assign out_discarded_count = drop_cnt_r;
  assign out_valid_count     = good_cnt_r;
  assign out_invalid_count   = bad_cnt_r;

endmodule

// ===== rtl/core/fixed_length_frame_sync_parser.sv =====
// Fixed-length frame sync parser, top level.
// Received bytes enter on the in_ channel, one word per accepted handshake.
// While hunting, words that are not header A or header B are dropped and
// counted. After a header the block collects FRAME_LEN words in total; the
// last one must be the footer that belongs to the header. A good frame is
// sent out as FRAME_LEN words of kind 1; every other input word produces one
// status word. Counters ride along on every result word and wrap at 32 bits.
// A status word is registered in the output register when its input word is
// accepted. The word that completes a good frame moves the controller to its
// emit state, from which the frame words are read from the frame store into
// the output register, one word per cycle while out_stall is low; the input
// is stalled until the last frame word has been read.
// No input is accepted while a frame streams out. in_stall also rises when the
// output register holds a word and out_stall is high; the word is held.
// Reset (rst_n low at a clock edge) returns to hunting, clears the counters,
// empties the output register and loads the default header and footer values.
// Configuration writes on cfg_ take effect at the next edge.
// Depends on flfs_pkg, flfs_ctrl, flfs_dpath and the assertion macro header.
`include "fixed_length_frame_sync_parser_assert.svh"

module fixed_length_frame_sync_parser #(
  parameter int FRAME_LEN = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_byte,
  output logic [4:0]  out_frame_pos,
  output logic        out_last,
  output logic [2:0]  out_event_res,
  output logic [31:0] out_discarded_count,
  output logic [31:0] out_valid_count,
  output logic [31:0] out_invalid_count
);

  flfs_pkg::cmd_t cmd;
  flfs_pkg::sts_t sts;
  logic           in_take;
  logic           out_held;
  logic           frm_word;
  logic           frm_more;
  logic [4:0]     pos_inc;

  // Control.
  flfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Storage and compare logic.
  flfs_dpath #(
    .FRAME_LEN (FRAME_LEN)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .rx_byte             (in_rx_byte),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_kind            (out_kind),
    .out_byte            (out_byte),
    .out_frame_pos       (out_frame_pos),
    .out_last            (out_last),
    .out_event_res       (out_event_res),
    .out_discarded_count (out_discarded_count),
    .out_valid_count     (out_valid_count),
    .out_invalid_count   (out_invalid_count)
  );

  // Handshake and frame terms used by the checks below.
  assign in_take  = in_valid && !in_stall;
  assign out_held = out_valid && out_stall;
  assign frm_word = out_valid && out_kind;
  assign frm_more = frm_word && !out_last && !out_stall;
  assign pos_inc  = out_frame_pos + 5'd1;

  // An input word is never taken while a stalled result still waits.
  `FLFS_ASSERT_SAME(a_no_take_over_stalled, clk, rst_n, in_take, !out_held)

  // A frame streams without gaps, one position per word.
  `FLFS_ASSERT_NEXT(a_frame_seq, clk, rst_n, frm_more, frm_word && out_frame_pos == $past(pos_inc))

  // Frame words always report the valid-frame event.
  `FLFS_ASSERT_SAME(a_frame_event, clk, rst_n, frm_word, out_event_res == flfs_pkg::EV_VALID)

endmodule
